/* sv/dasc_pkg.sv */
`timescale 1ns / 1ps

package dasc_pkg;

   localparam int DIGITS = 16;
   localparam int NIBBLE_BITS = 4;
   localparam int DIGIT_BITS = DIGITS * NIBBLE_BITS;
   localparam int WORD_BITS = 64;
   localparam int PREFIX_LEVELS = $clog2(DIGITS);

   localparam logic [NIBBLE_BITS:0] DECIMAL_MAX = 5'd9;
   localparam logic [NIBBLE_BITS:0] DECIMAL_BASE = 5'd10;

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_CMP = 2'd2
   } kind_type;

   typedef struct packed {
      logic                   bad;
      logic                   gt;
      logic                   lt;
      logic                   eq;
      logic                   carry_gen;
      logic                   carry_prop;
      logic [NIBBLE_BITS-1:0] sum0;
      logic [NIBBLE_BITS-1:0] sum1;
      logic [NIBBLE_BITS-1:0] dab0;
      logic [NIBBLE_BITS-1:0] dab1;
      logic [NIBBLE_BITS-1:0] dba0;
      logic [NIBBLE_BITS-1:0] dba1;
   } lane_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] digits;
      logic                 negative;
      logic                 carry_out;
      logic                 less_than;
      logic                 equal;
      logic                 bad_digit;
   } result_type;

   // Parallel prefix over generate and propagate: bit i of the result is the
   // carry (or borrow) leaving digit i when nothing enters digit 0.
   function automatic logic [DIGITS-1:0] group_generate(
      input logic [DIGITS-1:0] gen,
      input logic [DIGITS-1:0] prop
   );
      logic [DIGITS-1:0] g;
      logic [DIGITS-1:0] p;
      logic [DIGITS-1:0] g_next;
      logic [DIGITS-1:0] p_next;
      int                span;
      g = gen;
      p = prop;
      for (int lvl = 0; lvl < PREFIX_LEVELS; lvl++) begin
         span = 1 << lvl;
         g_next = g;
         p_next = p;
         for (int i = 0; i < DIGITS; i++) begin
            if (i >= span) begin
               g_next[i] = g[i] | (p[i] & g[i-span]);
               p_next[i] = p[i] & p[i-span];
            end
         end
         g = g_next;
         p = p_next;
      end
      return g;
   endfunction

endpackage

/* sv/decimal_add_sub_compare.sv */
// Throughput: one item per cycle while rsp_stall does not hold the output; the
// digit lanes and the prefix carry merge are each a single registered stage, so
// nothing iterates, and an item reaches the rsp_ ports through both registers.
// Reset (synchronous, active high) clears only the stage valid flags; the
// payload registers keep whatever they hold until the next item overwrites them.
`timescale 1ns / 1ps

module decimal_add_sub_compare
   import dasc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic [WORD_BITS-1:0] req_a_digits,
   input  logic [WORD_BITS-1:0] req_b_digits,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_result_digits,
   output logic                 rsp_negative,
   output logic                 rsp_carry_out,
   output logic                 rsp_less_than,
   output logic                 rsp_equal,
   output logic                 rsp_bad_digit
);

   lane_type   lane_w [DIGITS];
   lane_type   lane_ff [DIGITS];
   logic [1:0] kind_ff;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   result_type merge_w;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_advance;
   logic       s1_load;
   logic       req_accept;

   for (genvar i = 0; i < DIGITS; i++) begin : g_lane
      dasc_lane u_lane (
         .a_digit (req_a_digits[i*NIBBLE_BITS +: NIBBLE_BITS]),
         .b_digit (req_b_digits[i*NIBBLE_BITS +: NIBBLE_BITS]),
         .lane    (lane_w[i])
      );
   end

   dasc_merge u_merge (
      .kind   (kind_ff),
      .lanes  (lane_ff),
      .result (merge_w)
   );

   assign out_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_load = !s1_valid_ff || out_advance;
   assign req_stall = !s1_load;
   assign req_accept = req_valid && s1_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (s1_load) begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         lane_ff <= lane_w;
         kind_ff <= req_kind;
      end
      if (out_advance && s1_valid_ff) begin
         rsp_ff <= merge_w;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_digits = rsp_ff.digits;
   assign rsp_negative = rsp_ff.negative;
   assign rsp_carry_out = rsp_ff.carry_out;
   assign rsp_less_than = rsp_ff.less_than;
   assign rsp_equal = rsp_ff.equal;
   assign rsp_bad_digit = rsp_ff.bad_digit;

`ifndef SYNTHESIS
   a_bad_clears_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_digit) |-> (rsp_result_digits == '0 && !rsp_negative
         && !rsp_carry_out && !rsp_less_than && !rsp_equal))
      else $error("bad digit item carries a non-zero result");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_negative, rsp_carry_out, rsp_less_than, rsp_equal}))
      else $error("more than one result flag set");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && s1_valid_ff))
      else $error("input stalled while the pipeline has room");

   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ff)))
      else $error("stalled result lost or changed");
`endif

endmodule

/* sv/dasc_lane.sv */
`timescale 1ns / 1ps

module dasc_lane
   import dasc_pkg::*;
(
   input  logic [NIBBLE_BITS-1:0] a_digit,
   input  logic [NIBBLE_BITS-1:0] b_digit,
   output lane_type               lane
);

   logic [NIBBLE_BITS:0] a_ext;
   logic [NIBBLE_BITS:0] b_ext;
   logic [NIBBLE_BITS:0] sum;
   logic [NIBBLE_BITS:0] sum_inc;
   logic [NIBBLE_BITS:0] dab0_w;
   logic [NIBBLE_BITS:0] dab1_w;
   logic [NIBBLE_BITS:0] dba0_w;
   logic [NIBBLE_BITS:0] dba1_w;

   assign a_ext = {1'b0, a_digit};
   assign b_ext = {1'b0, b_digit};
   assign sum = a_ext + b_ext;
   assign sum_inc = sum + 5'd1;

   always_comb begin
      dab0_w = (a_ext < b_ext) ? a_ext + DECIMAL_BASE - b_ext : a_ext - b_ext;
      dab1_w = (a_ext <= b_ext) ? a_ext + DECIMAL_MAX - b_ext : a_ext - b_ext - 5'd1;
      dba0_w = (b_ext < a_ext) ? b_ext + DECIMAL_BASE - a_ext : b_ext - a_ext;
      dba1_w = (b_ext <= a_ext) ? b_ext + DECIMAL_MAX - a_ext : b_ext - a_ext - 5'd1;

      lane.bad = (a_ext > DECIMAL_MAX) || (b_ext > DECIMAL_MAX);
      lane.gt = a_ext > b_ext;
      lane.lt = a_ext < b_ext;
      lane.eq = a_ext == b_ext;
      lane.carry_gen = sum > DECIMAL_MAX;
      lane.carry_prop = sum == DECIMAL_MAX;
      lane.sum0 = (sum > DECIMAL_MAX) ? 4'(sum - DECIMAL_BASE) : sum[NIBBLE_BITS-1:0];
      lane.sum1 = (sum_inc > DECIMAL_MAX) ? 4'(sum_inc - DECIMAL_BASE)
                                          : sum_inc[NIBBLE_BITS-1:0];
      lane.dab0 = dab0_w[NIBBLE_BITS-1:0];
      lane.dab1 = dab1_w[NIBBLE_BITS-1:0];
      lane.dba0 = dba0_w[NIBBLE_BITS-1:0];
      lane.dba1 = dba1_w[NIBBLE_BITS-1:0];
   end

endmodule

/* sv/dasc_merge.sv */
`timescale 1ns / 1ps

module dasc_merge
   import dasc_pkg::*;
(
   input  logic [1:0] kind,
   input  lane_type   lanes [DIGITS],
   output result_type result
);

   logic [DIGITS-1:0]     carry_gen;
   logic [DIGITS-1:0]     carry_prop;
   logic [DIGITS-1:0]     lt_vec;
   logic [DIGITS-1:0]     gt_vec;
   logic [DIGITS-1:0]     eq_vec;
   logic [DIGITS-1:0]     bad_vec;
   logic [DIGITS-1:0]     carry_out_vec;
   logic [DIGITS-1:0]     borrow_ab_vec;
   logic [DIGITS-1:0]     borrow_ba_vec;
   logic [DIGITS-1:0]     carry_in;
   logic [DIGITS-1:0]     borrow_ab_in;
   logic [DIGITS-1:0]     borrow_ba_in;
   logic [DIGIT_BITS-1:0] sum_word;
   logic [DIGIT_BITS-1:0] diff_word;
   logic                  a_less;
   logic                  a_equal;
   logic                  any_bad;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         carry_gen[i] = lanes[i].carry_gen;
         carry_prop[i] = lanes[i].carry_prop;
         lt_vec[i] = lanes[i].lt;
         gt_vec[i] = lanes[i].gt;
         eq_vec[i] = lanes[i].eq;
         bad_vec[i] = lanes[i].bad;
      end
   end

   assign carry_out_vec = group_generate(carry_gen, carry_prop);
   assign borrow_ab_vec = group_generate(lt_vec, eq_vec);
   assign borrow_ba_vec = group_generate(gt_vec, eq_vec);

   assign carry_in = {carry_out_vec[DIGITS-2:0], 1'b0};
   assign borrow_ab_in = {borrow_ab_vec[DIGITS-2:0], 1'b0};
   assign borrow_ba_in = {borrow_ba_vec[DIGITS-2:0], 1'b0};

   // A borrow out of the top digit of a - b means a is the smaller magnitude.
   assign a_less = borrow_ab_vec[DIGITS-1];
   assign a_equal = &eq_vec;
   assign any_bad = |bad_vec;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         sum_word[i*NIBBLE_BITS +: NIBBLE_BITS] = carry_in[i] ? lanes[i].sum1
                                                              : lanes[i].sum0;
         if (a_less) begin
            diff_word[i*NIBBLE_BITS +: NIBBLE_BITS] = borrow_ba_in[i] ? lanes[i].dba1
                                                                      : lanes[i].dba0;
         end else begin
            diff_word[i*NIBBLE_BITS +: NIBBLE_BITS] = borrow_ab_in[i] ? lanes[i].dab1
                                                                      : lanes[i].dab0;
         end
      end
   end

   always_comb begin
      result = '0;
      if (any_bad) begin
         result.bad_digit = (kind == KIND_ADD) || (kind == KIND_SUB) || (kind == KIND_CMP);
      end else begin
         case (kind)
            KIND_ADD: begin
               result.digits = WORD_BITS'(sum_word);
               result.carry_out = carry_out_vec[DIGITS-1];
            end
            KIND_SUB: begin
               result.digits = WORD_BITS'(diff_word);
               result.negative = a_less;
            end
            KIND_CMP: begin
               result.less_than = a_less;
               result.equal = a_equal;
            end
            default: begin
               result = '0;
            end
         endcase
      end
   end

endmodule
